// ===== hw/rtl/rwbs_pkg.sv =====
// Shared constants, command and status types for the row-wise binary search unit.
// Used by the controller, the datapath and the top level. No dependencies.
package rwbs_pkg;

    // Table geometry.
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLUMNS = 16;
    localparam int TABLE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Fixed field widths of the request and result channels.
    localparam int DATA_W    = 32;
    localparam int ROW_W     = 4;
    localparam int COLUMN_W  = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Counter widths: wide enough for the register value and for the table size.
    localparam int ROW_LIM_W = $clog2(MAX_ROWS + 1);
    localparam int COL_LIM_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_CNT_W = (CFG_W > ROW_LIM_W) ? CFG_W : ROW_LIM_W;
    localparam int COL_CNT_W = (CFG_W > COL_LIM_W) ? CFG_W : COL_LIM_W;
    // Search bounds carry a sign bit so that the upper bound can reach minus one.
    localparam int BOUND_W   = COL_CNT_W + 1;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 1'd1;
    localparam logic [CFG_W-1:0]     ROWS_RESET         = 5'd3;
    localparam logic [CFG_W-1:0]     COLUMNS_RESET      = 5'd3;

    // Request operation codes.
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic start;
        logic next_row;
        logic probe;
        logic narrow_high;
        logic narrow_low;
        logic record_hit;
        logic publish;
    } rwbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rows_done;
        logic range_empty;
        logic key_equal;
        logic entry_greater;
        logic out_free;
    } rwbs_status_t;

endpackage

// ===== hw/rtl/rwbs_ctrl.sv =====
// Sequencing state machine of the row-wise binary search unit.
// Depends on rwbs_pkg for the command and status types.
module rwbs_ctrl
    import rwbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         op,
    output logic         in_stall,
    input  rwbs_status_t status,
    output rwbs_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_PROBE   = 4'b0010,
        ST_COMPARE = 4'b0100,
        ST_FINISH  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (op == OP_STORE))
                begin
                    cmd.store = 1'b1;
                end
                else if (in_accept)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // Walk to the next row once the current range has closed.
                if (status.rows_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.range_empty)
                begin
                    cmd.next_row = 1'b1;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                if (status.key_equal)
                begin
                    cmd.record_hit = 1'b1;
                    state_next     = ST_FINISH;
                end
                else if (status.entry_greater)
                begin
                    cmd.narrow_high = 1'b1;
                    state_next      = ST_PROBE;
                end
                else
                begin
                    cmd.narrow_low = 1'b1;
                    state_next     = ST_PROBE;
                end
            end
            ST_FINISH:
            begin
                // Hold the result until the output register can take it.
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/rwbs_datapath.sv =====
// Table memory, configuration registers, search bounds and result register.
// Depends on rwbs_pkg; driven by commands from rwbs_ctrl.
module rwbs_datapath
    import rwbs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic [ROW_W-1:0]            row,
    input  logic [COLUMN_W-1:0]         column,
    input  logic signed [DATA_W-1:0]    value,
    input  rwbs_cmd_t                   cmd,
    output rwbs_status_t                status,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [ROW_W-1:0]            row_pos,
    output logic [COLUMN_W-1:0]         column_pos
);

    logic [DATA_W-1:0]        mem [TABLE_DEPTH];

    logic [CFG_W-1:0]         rows_cfg_reg;
    logic [CFG_W-1:0]         cols_cfg_reg;
    logic [ROW_CNT_W-1:0]     rows_ext;
    logic [COL_CNT_W-1:0]     cols_ext;
    logic [ROW_CNT_W-1:0]     rows_lim;
    logic [COL_CNT_W-1:0]     cols_lim;

    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [ROW_CNT_W-1:0]     row_reg;
    logic signed [BOUND_W-1:0] low_reg;
    logic signed [BOUND_W-1:0] high_reg;
    logic [COL_CNT_W-1:0]     mid_reg;
    logic                     hit_reg;

    logic signed [BOUND_W-1:0] high_init;
    logic [BOUND_W:0]         bound_sum;
    logic [COL_CNT_W-1:0]     mid;
    logic [ADDR_W-1:0]        store_addr;
    logic [ADDR_W-1:0]        probe_addr;
    logic                     store_in_table;

    logic                     out_valid_reg;
    logic                     found_reg;
    logic [ROW_W-1:0]         row_pos_reg;
    logic [COLUMN_W-1:0]      column_pos_reg;

    // Clamp the configured range to the table size.
    assign rows_ext = ROW_CNT_W'(rows_cfg_reg);
    assign cols_ext = COL_CNT_W'(cols_cfg_reg);
    assign rows_lim = (rows_ext > ROW_CNT_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS) : rows_ext;
    assign cols_lim = (cols_ext > COL_CNT_W'(MAX_COLUMNS)) ? COL_CNT_W'(MAX_COLUMNS) : cols_ext;

    // Bounds arithmetic: the midpoint is taken only while both bounds are non-negative.
    assign high_init = $signed({1'b0, cols_lim}) - BOUND_W'(1);
    assign bound_sum = (BOUND_W + 1)'(unsigned'(low_reg)) + (BOUND_W + 1)'(unsigned'(high_reg));
    assign mid       = COL_CNT_W'(bound_sum >> 1);

    // Table addresses.
    assign store_in_table = (32'(row) < MAX_ROWS) && (32'(column) < MAX_COLUMNS);
    assign store_addr     = ADDR_W'(32'(row) * MAX_COLUMNS + 32'(column));
    assign probe_addr     = ADDR_W'(32'(row_reg) * MAX_COLUMNS + 32'(mid));

    // Status towards the controller.
    assign status.rows_done     = (row_reg == rows_lim);
    assign status.range_empty   = (low_reg > high_reg);
    assign status.key_equal     = (rd_data_reg == key_reg);
    assign status.entry_greater = (rd_data_reg > key_reg);
    assign status.out_free      = !out_valid_reg || !out_stall;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLUMNS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_IN_USE:    rows_cfg_reg <= cfg_data;
                CFG_COLUMNS_IN_USE: cols_cfg_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Table memory: one write port for stores, one registered read port for probes.
    always_ff @(posedge clk)
    begin
        if (cmd.store && store_in_table)
        begin
            mem[store_addr] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe)
        begin
            rd_data_reg <= mem[probe_addr];
        end
    end

    // Search registers: key, current row, bounds, probe position and hit flag.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg  <= value;
            row_reg  <= '0;
            low_reg  <= '0;
            high_reg <= high_init;
            hit_reg  <= 1'b0;
        end
        else if (cmd.next_row)
        begin
            row_reg  <= row_reg + ROW_CNT_W'(1);
            low_reg  <= '0;
            high_reg <= high_init;
        end
        else if (cmd.probe)
        begin
            mid_reg <= mid;
        end
        else if (cmd.narrow_high)
        begin
            high_reg <= $signed({1'b0, mid_reg}) - BOUND_W'(1);
        end
        else if (cmd.narrow_low)
        begin
            low_reg <= $signed({1'b0, mid_reg}) + BOUND_W'(1);
        end
        else if (cmd.record_hit)
        begin
            hit_reg <= 1'b1;
        end
    end

    // Result register: loaded on publish, emptied when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            found_reg      <= hit_reg;
            row_pos_reg    <= hit_reg ? ROW_W'(row_reg) : '0;
            column_pos_reg <= hit_reg ? COLUMN_W'(mid_reg) : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign row_pos    = row_pos_reg;
    assign column_pos = column_pos_reg;

endmodule

// ===== hw/rtl/row_wise_binary_search_unit.sv =====
// Top level of the row-wise binary search unit.
// Depends on rwbs_pkg, rwbs_ctrl and rwbs_datapath.
//
// Usage:
// A request carries op, row, column and value on the input channel; it is
// taken at a clock edge where in_valid is high and in_stall is low. A store
// request writes value into the table at (row, column) and gives no
// result. A search request visits rows 0 to rows_in_use-1 (at most 16) and
// runs a binary search over the first columns_in_use entries (at most 16)
// of each row, stopping at the first match. Each probe reads the table,
// then compares the entry with the key; once the range of a row has
// closed, the search moves on to the next row. The result (found, row_pos,
// column_pos) sits in an output register and is taken at an edge where
// out_valid is high and out_stall is low. While the result waits, a new
// request is still accepted; a second search holds in its last step until
// the output register is free. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the unit is idle,
// as the unit itself does not enforce this. Reset empties the result
// register and restores both range registers to 3; table entries are
// undefined until written.
module row_wise_binary_search_unit
    import rwbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     op,
    input  logic [ROW_W-1:0]         row,
    input  logic [COLUMN_W-1:0]      column,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     found,
    output logic [ROW_W-1:0]         row_pos,
    output logic [COLUMN_W-1:0]      column_pos
);

    rwbs_cmd_t    cmd;
    rwbs_status_t status;

    // Sequencer.
    rwbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Table, bounds and result register.
    rwbs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .row        (row),
        .column     (column),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .row_pos    (row_pos),
        .column_pos (column_pos)
    );

    // An accepted search request keeps the input side busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op == OP_SEARCH)) |=> in_stall)
        else $error("search request did not occupy the unit");

    // A miss reports both positions as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> ((row_pos == '0) && (column_pos == '0)))
        else $error("miss result carries a non-zero position");

    // A new result only appears at the end of a search, never from idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a search in progress");

    // A store request never leaves the unit busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op == OP_STORE)) |=> !in_stall)
        else $error("store request left the unit busy");

endmodule
